@@ design/srb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

  // Width of the sequence number and of the payload ports
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned PAY_W = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_SKIP    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // execute the captured command
    logic scan;  // one step of the skip search
  } srb_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic needs_scan; // captured command is a skip that must search
    logic scan_done;  // search ends at the current candidate
  } srb_stat_t;

endpackage

`default_nettype wire

@@ design/srb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/srb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srb_ctrl
  import srb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire srb_stat_t stat_i,
  output srb_ctrl_t      ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Sequence one item: capture, execute, then search for a skip
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          ctrl_o.exec = 1'b1;
          state_d     = stat_i.needs_scan ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stat_i.scan_done) begin
          ctrl_o.scan = 1'b1;
        end else if (stat_i.out_free) begin
          ctrl_o.scan = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/srb_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srb_datapath
  import srb_pkg::*;
#(
  parameter int unsigned WINDOW       = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire srb_ctrl_t        ctrl_i,
  output srb_stat_t             stat_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [SEQ_W-1:0] seq_index_i,
  input  wire logic [PAY_W-1:0] payload_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic      [PAY_W-1:0] out_payload_o,
  output logic                  hit_o,
  output logic                  dropped_o,
  output logic      [SEQ_W-1:0] head_index_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W:0]   WIN_EXT  = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);
  localparam logic [SEQ_W-1:0]  WIN_SEQ  = SEQ_W'(WINDOW);

  // Control state
  logic                  accept_en_q;
  logic [WINDOW-1:0]     valid_q, valid_d;
  logic [SEQ_W-1:0]      head_q, head_d;
  logic [SLOT_W-1:0]     head_slot_q, head_slot_d;
  logic                  out_valid_q, out_valid_d;

  // Item and search registers
  cmd_e                  cmd_q;
  logic [SEQ_W-1:0]      seq_q;
  logic [PAY_W-1:0]      pay_q;
  logic [SLOT_W-1:0]     k_q, k_d;
  logic [SLOT_W-1:0]     ptr_q, ptr_d;

  // Result registers
  logic [PAY_W-1:0]      res_pay_q, res_pay_d;
  logic                  res_hit_q, res_hit_d;
  logic                  res_drop_q, res_drop_d;
  logic [SEQ_W-1:0]      res_head_q;
  logic                  res_load;

  // Slot memory signals
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  // Enqueue window check and target slot
  logic [SEQ_W:0]        diff;
  logic                  enq_ok;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W-1:0]     enq_slot;

  // Head increment and search candidate
  logic [SEQ_W-1:0]      head_inc;
  logic [SLOT_W-1:0]     head_slot_inc;
  logic                  head_is_max;
  logic [SLOT_W-1:0]     ptr_inc;
  logic [SEQ_W-1:0]      cand;
  logic                  cand_hit;

  assign diff     = {1'b0, seq_q} - {1'b0, head_q};
  assign enq_ok   = accept_en_q && !diff[SEQ_W] && (diff[SEQ_W-1:0] < WIN_SEQ);
  assign slot_sum = {1'b0, head_slot_q} + {1'b0, diff[SLOT_W-1:0]};
  assign enq_slot = (slot_sum >= WIN_EXT) ? SLOT_W'(slot_sum - WIN_EXT)
                                          : slot_sum[SLOT_W-1:0];

  assign head_is_max   = (head_q == '1);
  assign head_inc      = head_q + SEQ_W'(1);
  assign head_slot_inc = (head_is_max || head_slot_q == SLOT_TOP) ? '0
                                                                  : head_slot_q + SLOT_W'(1);

  assign ptr_inc  = (ptr_q == SLOT_TOP) ? '0 : ptr_q + SLOT_W'(1);
  assign cand     = head_q + SEQ_W'(k_q);
  assign cand_hit = valid_q[ptr_q];

  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.needs_scan = (cmd_q == CMD_SKIP) && !head_is_max;
  assign stat_o.scan_done  = cand_hit || (k_q == SLOT_TOP) || (cand == '1);

  // Execute the command and step the skip search
  always_comb begin
    valid_d     = valid_q;
    head_d      = head_q;
    head_slot_d = head_slot_q;
    k_d         = k_q;
    ptr_d       = ptr_q;
    res_pay_d   = '0;
    res_hit_d   = 1'b0;
    res_drop_d  = 1'b0;
    res_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = enq_slot;
    if (ctrl_i.exec) begin
      unique case (cmd_q)
        CMD_ENQUEUE: begin
          res_load   = 1'b1;
          res_drop_d = !enq_ok;
          if (enq_ok) begin
            ram_we            = 1'b1;
            valid_d[enq_slot] = 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          res_load = 1'b1;
          if (valid_q[head_slot_q]) begin
            res_hit_d            = 1'b1;
            res_pay_d            = PAY_W'(ram_rdata);
            valid_d[head_slot_q] = 1'b0;
            head_d               = head_inc;
            head_slot_d          = head_slot_inc;
          end
        end
        CMD_SKIP: begin
          valid_d[head_slot_q] = 1'b0;
          if (head_is_max) begin
            // no candidate above the top number: wrap to zero
            res_load    = 1'b1;
            head_d      = head_inc;
            head_slot_d = head_slot_inc;
          end else begin
            k_d   = SLOT_W'(1);
            ptr_d = head_slot_inc;
          end
        end
        CMD_CLEAR: begin
          res_load    = 1'b1;
          valid_d     = '0;
          head_d      = '0;
          head_slot_d = '0;
        end
        default: begin
          res_load = 1'b0;
        end
      endcase
    end else if (ctrl_i.scan) begin
      if (cand_hit) begin
        // jump to the lowest stored number
        res_load    = 1'b1;
        head_d      = cand;
        head_slot_d = ptr_q;
      end else if (stat_o.scan_done) begin
        res_load    = 1'b1;
        head_d      = head_inc;
        head_slot_d = head_slot_inc;
      end else begin
        k_d   = k_q + SLOT_W'(1);
        ptr_d = ptr_inc;
      end
    end
  end

  // Output register: load a result, drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_en_q <= 1'b0;
      valid_q     <= '0;
      head_q      <= '0;
      head_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        accept_en_q <= cfg_wdata_i;
      end
      valid_q     <= valid_d;
      head_q      <= head_d;
      head_slot_q <= head_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item, advance the search, hold the result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(command_i);
      seq_q <= seq_index_i;
      pay_q <= payload_i;
    end
    k_q   <= k_d;
    ptr_q <= ptr_d;
    if (res_load) begin
      res_pay_q  <= res_pay_d;
      res_hit_q  <= res_hit_d;
      res_drop_q <= res_drop_d;
      res_head_q <= head_d;
    end
  end

  // Payload store, read at the head slot every cycle
  srb_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (PAYLOAD_BITS'(pay_q)),
    .raddr_i (head_slot_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = res_pay_q;
  assign hit_o         = res_hit_q;
  assign dropped_o     = res_drop_q;
  assign head_index_o  = res_head_q;

endmodule

`default_nettype wire

@@ design/sequence_reorder_buffer_top.sv @@
// Reorder buffer for numbered packets with a window of WINDOW slots.
// Input channel (in_valid_i / in_stall_o) carries a command, a sequence
// number and a payload handle; the output channel (out_valid_o /
// out_stall_i) returns exactly one result per item: the payload taken on a
// dequeue hit, the hit and drop flags and the head after the command.
// cfg_we_i / cfg_wdata_i write the accept enable; write it only while idle.
// Enqueue, dequeue and clear execute in the EXEC state once the output
// register is free and set out_valid_o from there; the controller then goes
// back to IDLE, where the next item is taken.
// Skip searches the valid bits one slot per cycle starting above the head,
// and its final step waits for a free output register; the slot payload
// memory has a registered read port.
// The result sits in an output register, so the next item is taken while a
// stalled result waits; execution of that item holds until the register
// frees up. Reset clears all valid bits, the head and the accept enable.
`timescale 1ns / 1ps
`default_nettype none

module sequence_reorder_buffer_top
  import srb_pkg::*;
#(
  parameter int unsigned WINDOW       = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [SEQ_W-1:0] seq_index_i,
  input  wire logic [PAY_W-1:0] payload_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [PAY_W-1:0] out_payload_o,
  output logic                  hit_o,
  output logic                  dropped_o,
  output logic      [SEQ_W-1:0] head_index_o
);

  srb_ctrl_t ctrl;
  srb_stat_t stat;

  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  srb_datapath #(
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (command_i),
    .seq_index_i   (seq_index_i),
    .payload_i     (payload_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_payload_o (out_payload_o),
    .hit_o         (hit_o),
    .dropped_o     (dropped_o),
    .head_index_o  (head_index_o)
  );

endmodule

`default_nettype wire
